// ===== hw/rtl/nir_pkg.sv =====
// Shared types, constants and helpers for the NEC IR frame decoder.
`default_nettype none

package nir_pkg;

  localparam int DEF_CODE_BITS = 32;
  localparam int DEF_TIME_BITS = 16;

  localparam int CFG_REGS     = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int TIME_W       = 16;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEAD_MARK_MIN  = 3'd0,
    REG_LEAD_MARK_MAX  = 3'd1,
    REG_LEAD_SPACE_MIN = 3'd2,
    REG_LEAD_SPACE_MAX = 3'd3,
    REG_PULSE_MIN      = 3'd4,
    REG_BIT_MARK_MAX   = 3'd5,
    REG_BIT_SPACE_MAX  = 3'd6,
    REG_ONE_THRESHOLD  = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] RST_LEAD_MARK_MIN  = 16'd8500;
  localparam logic [CFG_DATA_W-1:0] RST_LEAD_MARK_MAX  = 16'd9500;
  localparam logic [CFG_DATA_W-1:0] RST_LEAD_SPACE_MIN = 16'd4000;
  localparam logic [CFG_DATA_W-1:0] RST_LEAD_SPACE_MAX = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_PULSE_MIN      = 16'd400;
  localparam logic [CFG_DATA_W-1:0] RST_BIT_MARK_MAX   = 16'd700;
  localparam logic [CFG_DATA_W-1:0] RST_BIT_SPACE_MAX  = 16'd1800;
  localparam logic [CFG_DATA_W-1:0] RST_ONE_THRESHOLD  = 16'd1000;

  typedef enum logic {
    EV_EDGE  = 1'b0,
    EV_TIMER = 1'b1
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4
  } phase_t;

  // Classified event: everything the back end needs, no raw interval.
  typedef struct packed {
    ev_kind_t kind;
    logic     rising;
    logic     lead_mark_ok;
    logic     lead_space_ok;
    logic     bit_mark_ok;
    logic     bit_space_ok;
    logic     bit_one;
  } evt_class_t;

  function automatic logic in_window(input logic [TIME_W-1:0] t,
                                     input logic [CFG_DATA_W-1:0] lo,
                                     input logic [CFG_DATA_W-1:0] hi);
    return (t > lo) && (t < hi);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nir_front.sv =====
// Front end: timing registers and per-event window classification.
`default_nettype none

module nir_front #(
  parameter int TIME_BITS = nir_pkg::DEF_TIME_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              event_kind,
  input  wire logic                              edge_rising,
  input  wire logic [nir_pkg::TIME_W-1:0]        elapsed_us,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [nir_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output nir_pkg::evt_class_t                    q_item
);
  import nir_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MASK =
    (TIME_BITS >= TIME_W) ? {TIME_W{1'b1}} : TIME_W'((32'd1 << TIME_BITS) - 32'd1);

  logic [CFG_DATA_W-1:0] cfg_regs [CFG_REGS];
  logic [TIME_W-1:0]     t_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[REG_LEAD_MARK_MIN]  <= RST_LEAD_MARK_MIN;
      cfg_regs[REG_LEAD_MARK_MAX]  <= RST_LEAD_MARK_MAX;
      cfg_regs[REG_LEAD_SPACE_MIN] <= RST_LEAD_SPACE_MIN;
      cfg_regs[REG_LEAD_SPACE_MAX] <= RST_LEAD_SPACE_MAX;
      cfg_regs[REG_PULSE_MIN]      <= RST_PULSE_MIN;
      cfg_regs[REG_BIT_MARK_MAX]   <= RST_BIT_MARK_MAX;
      cfg_regs[REG_BIT_SPACE_MAX]  <= RST_BIT_SPACE_MAX;
      cfg_regs[REG_ONE_THRESHOLD]  <= RST_ONE_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;
  assign t_eff    = elapsed_us & TIME_MASK;

  always_comb begin
    q_item.kind          = ev_kind_t'(event_kind);
    q_item.rising        = edge_rising;
    q_item.lead_mark_ok  = in_window(t_eff, cfg_regs[REG_LEAD_MARK_MIN],
                                     cfg_regs[REG_LEAD_MARK_MAX]);
    q_item.lead_space_ok = in_window(t_eff, cfg_regs[REG_LEAD_SPACE_MIN],
                                     cfg_regs[REG_LEAD_SPACE_MAX]);
    q_item.bit_mark_ok   = in_window(t_eff, cfg_regs[REG_PULSE_MIN],
                                     cfg_regs[REG_BIT_MARK_MAX]);
    q_item.bit_space_ok  = in_window(t_eff, cfg_regs[REG_PULSE_MIN],
                                     cfg_regs[REG_BIT_SPACE_MAX]);
    q_item.bit_one       = t_eff > cfg_regs[REG_ONE_THRESHOLD];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nir_queue.sv =====
// Small FIFO of classified events between front and back end.
`default_nettype none

module nir_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire nir_pkg::evt_class_t push_item,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output nir_pkg::evt_class_t      head_item
);
  import nir_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  evt_class_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nir_back.sv =====
// Back end: frame state machine, code shifter and result register.
`default_nettype none

module nir_back #(
  parameter int CODE_BITS = nir_pkg::DEF_CODE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire nir_pkg::evt_class_t head_item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     frame_done,
  output logic [31:0]              frame_code,
  output logic [7:0]               command_byte,
  output logic                     timing_error,
  output logic [2:0]               decoder_phase
);
  import nir_pkg::*;

  localparam int CNT_W  = $clog2(CODE_BITS);
  localparam int WIDE_W = (CODE_BITS > 32) ? CODE_BITS : 32;

  phase_t                phase;
  phase_t                phase_next;
  logic [CNT_W-1:0]      bit_cnt;
  logic [CNT_W-1:0]      bit_cnt_next;
  logic [CODE_BITS-1:0]  code_shift;
  logic [CODE_BITS-1:0]  code_shift_next;
  logic                  done_c;
  logic                  err_c;
  logic                  expect_rise;
  logic [WIDE_W-1:0]     code_wide;

  // Out register is free when empty or being drained this cycle.
  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_cnt    <= '0;
      code_shift <= '0;
    end else if (pop) begin
      phase      <= phase_next;
      bit_cnt    <= bit_cnt_next;
      code_shift <= code_shift_next;
    end
  end

  always_comb begin
    expect_rise     = (phase == PH_LEAD_MARK) || (phase == PH_BIT_MARK);
    phase_next      = phase;
    bit_cnt_next    = bit_cnt;
    code_shift_next = code_shift;
    done_c          = 1'b0;
    err_c           = 1'b0;
    if (head_item.kind == EV_TIMER) begin
      phase_next = PH_IDLE;
    end else if (head_item.rising == expect_rise) begin
      case (phase)
        PH_IDLE: begin
          bit_cnt_next    = '0;
          code_shift_next = '0;
          phase_next      = PH_LEAD_MARK;
        end
        PH_LEAD_MARK: begin
          phase_next = head_item.lead_mark_ok ? PH_LEAD_SPACE : PH_IDLE;
          err_c      = !head_item.lead_mark_ok;
        end
        PH_LEAD_SPACE: begin
          phase_next = head_item.lead_space_ok ? PH_BIT_MARK : PH_IDLE;
          err_c      = !head_item.lead_space_ok;
        end
        PH_BIT_MARK: begin
          phase_next = head_item.bit_mark_ok ? PH_BIT_SPACE : PH_IDLE;
          err_c      = !head_item.bit_mark_ok;
        end
        PH_BIT_SPACE: begin
          if (head_item.bit_space_ok) begin
            code_shift_next = {code_shift[CODE_BITS-2:0], head_item.bit_one};
            bit_cnt_next    = bit_cnt + 1'b1;
            if (bit_cnt == CNT_W'(CODE_BITS - 1)) begin
              done_c     = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_BIT_MARK;
            end
          end else begin
            phase_next = PH_IDLE;
            err_c      = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  assign code_wide = done_c ? WIDE_W'(code_shift_next) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_done    <= done_c;
      frame_code    <= code_wide[31:0];
      command_byte  <= code_wide[15:8];
      timing_error  <= err_c;
      decoder_phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nec_ir_frame_decoder.sv =====
// Top level of the NEC IR frame decoder.
//
//   channel | signals                                    | direction | beat when
//   --------+--------------------------------------------+-----------+---------------------
//   in      | in_valid/in_stall, event_kind, edge_rising,| sink      | in_valid & !in_stall
//           | elapsed_us                                 |           |
//   out     | out_valid/out_stall, frame_done,           | source    | out_valid & !out_stall
//           | frame_code, command_byte, timing_error,    |           |
//           | decoder_phase                              |           |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | sink      | cfg_valid & cfg_ready
//
// Sustains one event beat per cycle while out_stall stays low; a beat's result
// reaches the output through the queue write at the accepting edge, then the
// state machine plus result register once the back end pops it.
// Throughput is set by the back end's phase update, made once per popped event.
// rst is synchronous: timing registers return to defaults, decoder to idle, queue
// empties. No clearing pass; cfg_ready is always high.
// out_stall backs up through the two-entry queue before in_stall rises.
`default_nettype none

module nec_ir_frame_decoder #(
  parameter int CODE_BITS = nir_pkg::DEF_CODE_BITS,
  parameter int TIME_BITS = nir_pkg::DEF_TIME_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              event_kind,
  input  wire logic                              edge_rising,
  input  wire logic [nir_pkg::TIME_W-1:0]        elapsed_us,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   frame_done,
  output logic [31:0]                            frame_code,
  output logic [7:0]                             command_byte,
  output logic                                   timing_error,
  output logic [2:0]                             decoder_phase,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [nir_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nir_pkg::*;

  // front -> queue
  logic       q_push;
  logic       q_full;
  evt_class_t q_item;
  // queue -> back
  logic       q_pop;
  logic       q_head_valid;
  evt_class_t q_head;

  // Front classifies each event against all windows up front, so the back
  // end only selects which verdict matters for its current phase.
  nir_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .event_kind  (event_kind),
    .edge_rising (edge_rising),
    .elapsed_us  (elapsed_us),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  nir_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  // Back end owns phase, bit count and code shifter; one event per pop.
  nir_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head_item     (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_done    (frame_done),
    .frame_code    (frame_code),
    .command_byte  (command_byte),
    .timing_error  (timing_error),
    .decoder_phase (decoder_phase)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/nir_checker.sv =====
// Port-level checks for the NEC IR frame decoder, bound to the top level.
`default_nettype none

module nir_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        frame_done,
  input wire logic [31:0] frame_code,
  input wire logic [7:0]  command_byte,
  input wire logic        timing_error,
  input wire logic [2:0]  decoder_phase
);
  import nir_pkg::*;

  // Nothing comes out the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A completed frame or a window miss leaves the decoder idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_done || timing_error)) |-> (decoder_phase == PH_IDLE))
    else $error("frame end or error without returning to idle");

  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && timing_error))
    else $error("frame_done and timing_error together");

  // Code fields only carry data on a completed frame.
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> ((frame_code == '0) && (command_byte == '0)))
    else $error("code reported without a completed frame");

  a_cmd_slice: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (command_byte == frame_code[15:8]))
    else $error("command_byte does not match frame_code");

endmodule

bind nec_ir_frame_decoder nir_checker u_nir_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .frame_done    (frame_done),
  .frame_code    (frame_code),
  .command_byte  (command_byte),
  .timing_error  (timing_error),
  .decoder_phase (decoder_phase)
);

`default_nettype wire

// ===== dv/nec_ir_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the NEC IR frame decoder: directed table, random frames.
module nec_ir_frame_decoder_tb;
  import nir_pkg::*;

  // One result beat as seen on the output port.
  typedef struct packed {
    logic        done;
    logic [31:0] code;
    logic [7:0]  cmd;
    logic        err;
    logic [2:0]  ph;
  } ir_result_t;

  // Directed stimulus row; res is used only when typed is set.
  typedef struct {
    ev_kind_t    kind;
    logic        rising;
    logic [15:0] us;
    logic        typed;
    ir_result_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        event_kind = 1'b0;
  logic        edge_rising = 1'b0;
  logic [15:0] elapsed_us = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_done;
  logic [31:0] frame_code;
  logic [7:0]  command_byte;
  logic        timing_error;
  logic [2:0]  decoder_phase;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  nec_ir_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .event_kind    (event_kind),
    .edge_rising   (edge_rising),
    .elapsed_us    (elapsed_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_done    (frame_done),
    .frame_code    (frame_code),
    .command_byte  (command_byte),
    .timing_error  (timing_error),
    .decoder_phase (decoder_phase),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #20_000_000;
    $display("[nec_ir_frame_decoder] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: window registers and frame state, updated per accepted beat.
  // ---------------------------------------------------------------------------
  logic [15:0] win_reg [CFG_REGS] = '{RST_LEAD_MARK_MIN, RST_LEAD_MARK_MAX,
                                      RST_LEAD_SPACE_MIN, RST_LEAD_SPACE_MAX,
                                      RST_PULSE_MIN, RST_BIT_MARK_MAX,
                                      RST_BIT_SPACE_MAX, RST_ONE_THRESHOLD};
  logic [15:0] cfg_plan [CFG_REGS];
  phase_t      dec_phase = PH_IDLE;
  logic [5:0]  dec_bits = 6'd0;
  logic [31:0] dec_code = 32'd0;
  logic        dec_want_rise = 1'b0;

  ir_result_t  pending_results [$];
  int          fails = 0;
  int          live_events = 0;   // beats that actually move the decoder
  int          idle_rate = 0;     // odds out of 64 of starting an idle or stall burst

  // Open interval test, both ends exclusive.
  function automatic logic fits(logic [15:0] t, logic [15:0] lo, logic [15:0] hi);
    return (t > lo) && (t < hi);
  endfunction

  function automatic void drop_to_idle();
    dec_phase     = PH_IDLE;
    dec_want_rise = 1'b0;
  endfunction

  // Advance the mirror by one event and return the result beat it produces.
  function automatic ir_result_t decode_event(ev_kind_t kind, logic rising,
                                              logic [15:0] t);
    ir_result_t r;
    r = '0;
    if (kind == EV_TIMER) begin
      drop_to_idle();
    end else if (rising == dec_want_rise) begin
      case (dec_phase)
        PH_IDLE: begin
          // elapsed time is meaningless here: this edge starts the lead mark
          dec_bits      = 6'd0;
          dec_code      = 32'd0;
          dec_phase     = PH_LEAD_MARK;
          dec_want_rise = 1'b1;
        end
        PH_LEAD_MARK: begin
          if (fits(t, win_reg[REG_LEAD_MARK_MIN], win_reg[REG_LEAD_MARK_MAX])) begin
            dec_phase     = PH_LEAD_SPACE;
            dec_want_rise = 1'b0;
          end else begin
            drop_to_idle();
            r.err = 1'b1;
          end
        end
        PH_LEAD_SPACE: begin
          if (fits(t, win_reg[REG_LEAD_SPACE_MIN], win_reg[REG_LEAD_SPACE_MAX])) begin
            dec_phase     = PH_BIT_MARK;
            dec_want_rise = 1'b1;
          end else begin
            drop_to_idle();
            r.err = 1'b1;
          end
        end
        PH_BIT_MARK: begin
          if (fits(t, win_reg[REG_PULSE_MIN], win_reg[REG_BIT_MARK_MAX])) begin
            dec_phase     = PH_BIT_SPACE;
            dec_want_rise = 1'b0;
          end else begin
            drop_to_idle();
            r.err = 1'b1;
          end
        end
        default: begin
          if (fits(t, win_reg[REG_PULSE_MIN], win_reg[REG_BIT_SPACE_MAX])) begin
            // long space is a one; first bit ends up in the MSB
            dec_code = {dec_code[30:0], t > win_reg[REG_ONE_THRESHOLD]};
            dec_bits = dec_bits + 6'd1;
            if (dec_bits >= 6'd32) begin
              r.done = 1'b1;
              r.code = dec_code;
              r.cmd  = dec_code[15:8];
              drop_to_idle();
            end else begin
              dec_phase     = PH_BIT_MARK;
              dec_want_rise = 1'b1;
            end
          end else begin
            drop_to_idle();
            r.err = 1'b1;
          end
        end
      endcase
    end
    r.ph = dec_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. One beat per call; a random idle burst may come first.
  // ---------------------------------------------------------------------------
  task automatic send_event(ev_kind_t kind, logic rising, logic [15:0] us,
                            logic typed, ir_result_t typed_res);
    ir_result_t r;
    int gap;
    if (idle_rate != 0 && $urandom_range(0, 63) < idle_rate) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    event_kind  <= kind;
    edge_rising <= rising;
    elapsed_us  <= us;
    do @(posedge clk); while (in_stall);
    // beat taken at this edge
    if (!(kind == EV_TIMER ? dec_phase == PH_IDLE : rising != dec_want_rise))
      live_events++;
    r = decode_event(kind, rising, us);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send_plain(ev_kind_t kind, logic rising, logic [15:0] us);
    send_event(kind, rising, us, 1'b0, '0);
  endtask

  // Value strictly inside (lo, hi), leaning on the edges; random if the window is empty.
  function automatic logic [15:0] pick_between(int lo, int hi);
    if (hi - lo < 2) return 16'($urandom);
    case ($urandom_range(0, 7))
      0:       return 16'(lo + 1);
      1:       return 16'(hi - 1);
      default: return 16'($urandom_range(lo + 1, hi - 1));
    endcase
  endfunction

  // Bit space that decodes as the requested bit value when the windows allow it.
  function automatic logic [15:0] pick_space(logic one);
    int lo, hi, thr, a, b;
    lo  = win_reg[REG_PULSE_MIN];
    hi  = win_reg[REG_BIT_SPACE_MAX];
    thr = win_reg[REG_ONE_THRESHOLD];
    if (one) begin
      a = (thr > lo) ? thr : lo;
      b = hi;
    end else begin
      a = lo;
      b = (thr + 1 < hi) ? thr + 1 : hi;
    end
    if (b - a >= 2) return pick_between(a, b);
    return pick_between(lo, hi);
  endfunction

  // Interval that falls outside the window, or a random one.
  function automatic logic [15:0] miss_value(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      2:       return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // A full NEC frame with random code bits; about one in four is broken somewhere.
  task automatic send_frame();
    int          bad_at, k, how;
    logic        rising;
    logic [15:0] lo, hi, us;
    if (dec_phase != PH_IDLE) send_plain(EV_TIMER, 1'($urandom), 16'($urandom));
    send_plain(EV_EDGE, 1'b0, 16'($urandom));
    bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65) : -1;
    for (k = 0; k < 66; k++) begin
      rising = (k % 2 == 0);
      case (k)
        0: begin
          lo = win_reg[REG_LEAD_MARK_MIN];
          hi = win_reg[REG_LEAD_MARK_MAX];
        end
        1: begin
          lo = win_reg[REG_LEAD_SPACE_MIN];
          hi = win_reg[REG_LEAD_SPACE_MAX];
        end
        default: begin
          lo = win_reg[REG_PULSE_MIN];
          hi = rising ? win_reg[REG_BIT_MARK_MAX] : win_reg[REG_BIT_SPACE_MAX];
        end
      endcase
      us = (k >= 2 && !rising) ? pick_space(1'($urandom)) : pick_between(lo, hi);
      if (k == bad_at) begin
        how = $urandom_range(0, 2);
        if (how == 0) begin
          // stray edge of the wrong polarity; decoder should shrug it off
          send_plain(EV_EDGE, !rising, 16'($urandom));
        end else if (how == 1) begin
          send_plain(EV_TIMER, rising, us);
          return;
        end else begin
          send_plain(EV_EDGE, rising, miss_value(lo, hi));
          return;
        end
      end
      send_plain(EV_EDGE, rising, us);
    end
  endtask

  // Mix of frames and short noise runs until enough beats moved the decoder.
  // Ends with a timer overflow so the decoder sits in idle.
  task automatic run_random(int budget);
    int stop_at, n;
    stop_at = live_events + budget;
    while (live_events < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) send_plain(ev_kind_t'($urandom_range(0, 1)), 1'($urandom),
                              16'($urandom));
      end else begin
        send_frame();
      end
    end
    send_plain(EV_TIMER, 1'b0, 16'($urandom));
  endtask

  // Write all eight window registers from cfg_plan once the pipe has drained.
  task automatic load_windows();
    int i;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (i = 0; i < CFG_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= cfg_plan[i];
      do @(posedge clk); while (!cfg_ready);
      win_reg[i] = cfg_plan[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Plausible windows around random centers, kept well below 16-bit overflow.
  task automatic plan_random_windows();
    int pm;
    cfg_plan[REG_LEAD_MARK_MIN]  = 16'($urandom_range(100, 9000));
    cfg_plan[REG_LEAD_MARK_MAX]  = cfg_plan[REG_LEAD_MARK_MIN] + 16'($urandom_range(2, 2000));
    cfg_plan[REG_LEAD_SPACE_MIN] = 16'($urandom_range(100, 5000));
    cfg_plan[REG_LEAD_SPACE_MAX] = cfg_plan[REG_LEAD_SPACE_MIN] + 16'($urandom_range(2, 2000));
    pm = $urandom_range(0, 500);
    cfg_plan[REG_PULSE_MIN]      = 16'(pm);
    cfg_plan[REG_BIT_MARK_MAX]   = 16'(pm + $urandom_range(2, 800));
    cfg_plan[REG_BIT_SPACE_MAX]  = 16'(pm + $urandom_range(2, 3000));
    cfg_plan[REG_ONE_THRESHOLD]  = 16'($urandom_range(pm, cfg_plan[REG_BIT_SPACE_MAX]));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, then a field-by-field compare per beat.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (idle_rate != 0 && $urandom_range(0, 63) < idle_rate) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 18);
    end else begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    ir_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time,
                 {frame_done, frame_code, command_byte, timing_error, decoder_phase});
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_done", 32'(want.done), 32'(frame_done));
        check_field("frame_code", want.code, frame_code);
        check_field("command_byte", 32'(want.cmd), 32'(command_byte));
        check_field("timing_error", 32'(want.err), 32'(timing_error));
        check_field("decoder_phase", 32'(want.ph), 32'(decoder_phase));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows, run against the reset windows. Typed rows carry their own
  // answer; the bit rows near the end go through the mirror.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [28] = '{
    // timer overflow while idle: nothing happens
    '{EV_TIMER, 1'b0, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_IDLE}},
    // rising edge while idle is the wrong polarity
    '{EV_EDGE,  1'b1, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_IDLE}},
    // falling edge starts the lead mark, elapsed ignored
    '{EV_EDGE,  1'b0, 16'hFFFF,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    '{EV_EDGE,  1'b0, 16'd9000,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    // lead mark too short, then both window edges (exclusive)
    '{EV_EDGE,  1'b1, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b1, PH_IDLE}},
    '{EV_EDGE,  1'b0, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    '{EV_EDGE,  1'b1, 16'd8500,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b1, PH_IDLE}},
    '{EV_EDGE,  1'b0, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    '{EV_EDGE,  1'b1, 16'd9500,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b1, PH_IDLE}},
    '{EV_EDGE,  1'b0, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    '{EV_EDGE,  1'b1, 16'd8501,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_SPACE}},
    '{EV_EDGE,  1'b1, 16'd9000,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_SPACE}},
    // overflow mid-frame drops to idle without an error flag
    '{EV_TIMER, 1'b1, 16'd4500,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_IDLE}},
    '{EV_EDGE,  1'b0, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    '{EV_EDGE,  1'b1, 16'd9499,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_SPACE}},
    '{EV_EDGE,  1'b0, 16'd4000,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b1, PH_IDLE}},
    '{EV_EDGE,  1'b0, 16'd0,     1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_MARK}},
    '{EV_EDGE,  1'b1, 16'd9000,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_LEAD_SPACE}},
    '{EV_EDGE,  1'b0, 16'd4999,  1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_BIT_MARK}},
    // bit mark exactly at pulse_min misses
    '{EV_EDGE,  1'b1, 16'd400,   1'b1, '{1'b0, 32'd0, 8'd0, 1'b1, PH_IDLE}},
    '{EV_EDGE,  1'b0, 16'd0,     1'b0, '0},
    '{EV_EDGE,  1'b1, 16'd9000,  1'b0, '0},
    '{EV_EDGE,  1'b0, 16'd4001,  1'b0, '0},
    '{EV_EDGE,  1'b1, 16'd699,   1'b1, '{1'b0, 32'd0, 8'd0, 1'b0, PH_BIT_SPACE}},
    // space at the threshold is a zero, one above it is a one
    '{EV_EDGE,  1'b0, 16'd1000,  1'b0, '0},
    '{EV_EDGE,  1'b1, 16'd401,   1'b0, '0},
    '{EV_EDGE,  1'b0, 16'd1001,  1'b0, '0},
    '{EV_EDGE,  1'b1, 16'd700,   1'b1, '{1'b0, 32'd0, 8'd0, 1'b1, PH_IDLE}}
  };

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    idle_rate = 10;
    foreach (directed_rows[i])
      send_event(directed_rows[i].kind, directed_rows[i].rising, directed_rows[i].us,
                 directed_rows[i].typed, directed_rows[i].res);

    // reset windows: the bulk of the well-formed frames
    run_random(60);

    // every window empty at the low extreme
    for (i = 0; i < CFG_REGS; i++) cfg_plan[i] = 16'd0;
    load_windows();
    run_random(15);

    // every window empty at the high extreme
    for (i = 0; i < CFG_REGS; i++) cfg_plan[i] = 16'hFFFF;
    load_windows();
    run_random(15);

    // widest windows; no idling on either side here
    cfg_plan[REG_LEAD_MARK_MIN]  = 16'd0;
    cfg_plan[REG_LEAD_MARK_MAX]  = 16'hFFFF;
    cfg_plan[REG_LEAD_SPACE_MIN] = 16'd0;
    cfg_plan[REG_LEAD_SPACE_MAX] = 16'hFFFF;
    cfg_plan[REG_PULSE_MIN]      = 16'd0;
    cfg_plan[REG_BIT_MARK_MAX]   = 16'hFFFF;
    cfg_plan[REG_BIT_SPACE_MAX]  = 16'hFFFF;
    cfg_plan[REG_ONE_THRESHOLD]  = 16'($urandom);
    load_windows();
    idle_rate = 0;
    run_random(60);

    // two random timing sets with varying idle pressure
    repeat (2) begin
      plan_random_windows();
      load_windows();
      idle_rate = $urandom_range(4, 24);
      run_random(60);
    end

    // tail of the run: one more random set, both sides run flat out
    plan_random_windows();
    load_windows();
    idle_rate = 0;
    run_random(60);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("[nec_ir_frame_decoder] OK");
    end else begin
      $display("[nec_ir_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule
